// ===== rtl/vmpi_pkg.sv =====
// shared types, codes and helper functions of the voxel map point insert unit
`default_nettype none
package vmpi_pkg;

  // field widths
  localparam int unsigned CoordW = 24;
  localparam int unsigned KeyW   = 48;
  localparam int unsigned MagW   = 25;
  localparam int unsigned ProdW  = 50;
  localparam int unsigned DistW  = 52;

  // configuration register indexes
  localparam logic [2:0] REG_VOXEL_SIZE = 3'd0;
  localparam logic [2:0] REG_MAX_POINTS = 3'd1;
  localparam logic [2:0] REG_MIN_SPACE  = 3'd2;
  localparam logic [2:0] REG_MIN_GROW   = 3'd3;
  localparam logic [2:0] REG_KEEP_RAD   = 3'd4;

  // result status codes
  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_NEW     = 3'd1,
    ST_CLOSE   = 3'd2,
    ST_FULL    = 3'd3,
    ST_SPARSE  = 3'd4,
    ST_TFULL   = 3'd5,
    ST_REMOVED = 3'd6
  } status_e;

  // magnitude of a signed coordinate
  function automatic logic [CoordW-1:0] coord_mag(input logic signed [CoordW-1:0] c);
    logic [CoordW-1:0] r;
    r = c[CoordW-1] ? CoordW'(-c) : CoordW'(c);
    return r;
  endfunction

  // absolute difference of two signed coordinates
  function automatic logic [MagW-1:0] abs_diff(input logic signed [CoordW-1:0] a,
                                               input logic signed [CoordW-1:0] b);
    logic signed [MagW-1:0] d;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    return d[MagW-1] ? MagW'(-d) : MagW'(d);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/vmpi_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none
module vmpi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                  wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/voxel_map_point_insert_unit.sv =====
// voxel map point insert unit: top level with sequencer, divider and squarer
// insert item: setup, then the key by division, then a lookup over all slots, then for an existing
//   voxel with room a distance to each stored point and a decision; the divider is a shared
//   restoring divider, the slot scan uses one ram read port and the squarer is shared
// removal item: setup, then one slot checked at a time; a used slot has its first point read and compared
// one item at a time: busy stays high from accept to the result strobe; results cannot stall
// reset loads the config defaults and clears control, then a clearing pass empties the
//   slot table while busy is high
`default_nettype none
module voxel_map_point_insert_unit
  import vmpi_pkg::*;
#(
  parameter int unsigned VOXEL_SLOTS      = 256,
  parameter int unsigned POINTS_PER_VOXEL = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     func_i,
  input  wire logic signed [23:0]       x_coord_i,
  input  wire logic signed [23:0]       y_coord_i,
  input  wire logic signed [23:0]       z_coord_i,
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output logic [5:0]                    voxel_points_o,
  output logic [8:0]                    removed_voxels_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [4:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned SW  = $clog2(VOXEL_SLOTS);
  localparam int unsigned SCW = SW + 1;
  localparam int unsigned CW  = $clog2(POINTS_PER_VOXEL + 1);
  localparam int unsigned PAW = $clog2(VOXEL_SLOTS * POINTS_PER_VOXEL);
  localparam int unsigned MW  = 1 + 2 * CW;
  localparam int unsigned NW  = 8;
  localparam int unsigned PW  = 3 * CoordW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_DIV, S_LOOK, S_PNEXT, S_PRD, S_PCAP,
    S_DIST, S_ICMP, S_DEC, S_RMETA, S_RCHK, S_RCMP
  } state_e;

  // configuration registers
  logic [15:0] voxel_size_q;
  logic [5:0]  max_points_q;
  logic [15:0] min_space_q;
  logic [5:0]  min_grow_q;
  logic [22:0] keep_rad_q;

  // sequencer and datapath registers
  state_e            state_q;
  logic [2:0]        k_q;
  logic [SCW-1:0]    sc_q;
  logic              rd_v_q;
  logic [SW-1:0]     rd_a_q;
  logic              found_q;
  logic [SW-1:0]     hit_q;
  logic              freef_q;
  logic [SW-1:0]     fr_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     cap_q;
  logic [CW-1:0]     idx_q;
  logic [PAW-1:0]    pa_q;
  logic              func_q;
  logic signed [CoordW-1:0] x_q, y_q, z_q;
  logic signed [CoordW-1:0] px_q, py_q, pz_q;
  logic [KeyW-1:0]   key_q;
  logic [15:0]       rem_q;
  logic [CoordW-1:0] dq_q;
  logic [1:0]        ci_q;
  logic [4:0]        bc_q;
  logic [MagW-1:0]   mop_q;
  logic [ProdW-1:0]  prod_q;
  logic [DistW-1:0]  acc_q;
  logic [DistW-1:0]  best_q;
  logic [DistW-1:0]  lim_q;
  logic [8:0]        removed_q;
  logic [2:0]        status_q;
  logic [5:0]        vpts_q;
  logic              done_q;
  logic              pt_we_q;
  logic [PAW-1:0]    pt_wa_q;
  logic              meta_we_q;
  logic              key_we_q;
  logic [SW-1:0]     meta_wa_q;
  logic [MW-1:0]     meta_wd_q;

  // ram ports
  logic              meta_we;
  logic [SW-1:0]     meta_waddr;
  logic [MW-1:0]     meta_wdata;
  logic [SW-1:0]     slot_raddr;
  logic [MW-1:0]     meta_rdata;
  logic [KeyW-1:0]   key_rdata;
  logic [PW-1:0]     pt_rdata;

  // derived values
  logic [15:0]       vs_eff;
  logic [16:0]       div_sh;
  logic              div_ge;
  logic [15:0]       rem_n;
  logic [CoordW-1:0] dq_n;
  logic              csign;
  logic [15:0]       kpart;
  logic [CW-1:0]     cap_new;
  logic              m_valid;
  logic [CW-1:0]     m_count;
  logic [CW-1:0]     m_cap;
  logic [DistW-1:0]  prod_ext;
  logic [8:0]        removed_inc;

  assign vs_eff      = (voxel_size_q == 16'd0) ? 16'd1 : voxel_size_q;
  assign prod_ext    = DistW'(prod_q);
  assign removed_inc = (removed_q == 9'd511) ? removed_q : removed_q + 9'd1;

  // meta entry fields
  assign m_valid = meta_rdata[MW-1];
  assign m_count = meta_rdata[2*CW-1:CW];
  assign m_cap   = meta_rdata[CW-1:0];

  // capacity of a new voxel, at least one and clamped to the point store row
  always_comb begin
    if (max_points_q == 6'd0) begin
      cap_new = CW'(1);
    end else if (NW'(max_points_q) > NW'(POINTS_PER_VOXEL)) begin
      cap_new = CW'(POINTS_PER_VOXEL);
    end else begin
      cap_new = CW'(max_points_q);
    end
  end

  // one restoring divider step
  always_comb begin
    div_sh = {rem_q, dq_q[CoordW-1]};
    div_ge = div_sh >= {1'b0, vs_eff};
    rem_n  = div_ge ? 16'(div_sh - {1'b0, vs_eff}) : div_sh[15:0];
    dq_n   = {dq_q[CoordW-2:0], div_ge};
  end

  // key part saturation with the sign of the coordinate being divided
  always_comb begin
    case (ci_q)
      2'd0:    csign = x_q[CoordW-1];
      2'd1:    csign = y_q[CoordW-1];
      default: csign = z_q[CoordW-1];
    endcase
    if (!csign) begin
      kpart = (dq_n > CoordW'(32767)) ? 16'h7fff : dq_n[15:0];
    end else begin
      kpart = (dq_n > CoordW'(32768)) ? 16'h8000 : 16'(-dq_n);
    end
  end

  // slot table read address follows the scan counter
  assign slot_raddr = (sc_q < SCW'(VOXEL_SLOTS)) ? sc_q[SW-1:0] : '0;

  // meta write port shared with the clearing pass
  assign meta_we    = (state_q == S_CLEAR) || meta_we_q;
  assign meta_waddr = (state_q == S_CLEAR) ? sc_q[SW-1:0] : meta_wa_q;
  assign meta_wdata = (state_q == S_CLEAR) ? '0 : meta_wd_q;

  vmpi_ram #(.WIDTH(MW), .DEPTH(VOXEL_SLOTS)) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_waddr),
    .wdata_i(meta_wdata),
    .raddr_i(slot_raddr),
    .rdata_o(meta_rdata)
  );

  vmpi_ram #(.WIDTH(KeyW), .DEPTH(VOXEL_SLOTS)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we_q),
    .waddr_i(meta_wa_q),
    .wdata_i(key_q),
    .raddr_i(slot_raddr),
    .rdata_o(key_rdata)
  );

  vmpi_ram #(.WIDTH(PW), .DEPTH(VOXEL_SLOTS * POINTS_PER_VOXEL)) u_point_ram (
    .clk_i  (clk_i),
    .we_i   (pt_we_q),
    .waddr_i(pt_wa_q),
    .wdata_i({x_q, y_q, z_q}),
    .raddr_i(pa_q),
    .rdata_o(pt_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voxel_size_q <= 16'd819;
      max_points_q <= 6'd20;
      min_space_q  <= 16'd51;
      min_grow_q   <= 6'd0;
      keep_rad_q   <= 23'd102400;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_VOXEL_SIZE: voxel_size_q <= pwdata[15:0];
        REG_MAX_POINTS: max_points_q <= pwdata[5:0];
        REG_MIN_SPACE:  min_space_q  <= pwdata[15:0];
        REG_MIN_GROW:   min_grow_q   <= pwdata[5:0];
        REG_KEEP_RAD:   keep_rad_q   <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  // configuration read back
  always_comb begin
    case (paddr[4:2])
      REG_VOXEL_SIZE: prdata = 32'(voxel_size_q);
      REG_MAX_POINTS: prdata = 32'(max_points_q);
      REG_MIN_SPACE:  prdata = 32'(min_space_q);
      REG_MIN_GROW:   prdata = 32'(min_grow_q);
      REG_KEEP_RAD:   prdata = 32'(keep_rad_q);
      default:        prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  // sequencer, shared divider and squarer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      k_q       <= '0;
      sc_q      <= '0;
      rd_v_q    <= 1'b0;
      rd_a_q    <= '0;
      found_q   <= 1'b0;
      hit_q     <= '0;
      freef_q   <= 1'b0;
      fr_q      <= '0;
      cnt_q     <= '0;
      cap_q     <= '0;
      idx_q     <= '0;
      pa_q      <= '0;
      func_q    <= 1'b0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
      px_q      <= '0;
      py_q      <= '0;
      pz_q      <= '0;
      key_q     <= '0;
      rem_q     <= '0;
      dq_q      <= '0;
      ci_q      <= '0;
      bc_q      <= '0;
      mop_q     <= '0;
      prod_q    <= '0;
      acc_q     <= '0;
      best_q    <= '0;
      lim_q     <= '0;
      removed_q <= '0;
      status_q  <= '0;
      vpts_q    <= '0;
      done_q    <= 1'b0;
      pt_we_q   <= 1'b0;
      pt_wa_q   <= '0;
      meta_we_q <= 1'b0;
      key_we_q  <= 1'b0;
      meta_wa_q <= '0;
      meta_wd_q <= '0;
    end else begin
      done_q    <= 1'b0;
      pt_we_q   <= 1'b0;
      meta_we_q <= 1'b0;
      key_we_q  <= 1'b0;
      prod_q    <= ProdW'(mop_q) * ProdW'(mop_q);
      case (state_q)
        // sweep the slot table empty
        S_CLEAR: begin
          if (sc_q == SCW'(VOXEL_SLOTS - 1)) begin
            sc_q    <= '0;
            state_q <= S_IDLE;
          end else begin
            sc_q <= sc_q + 1'b1;
          end
        end
        // take the next item
        S_IDLE: begin
          if (start) begin
            func_q    <= func_i;
            x_q       <= x_coord_i;
            y_q       <= y_coord_i;
            z_q       <= z_coord_i;
            removed_q <= '0;
            k_q       <= '0;
            state_q   <= S_SETUP;
          end
        end
        // square the thresholds through the shared squarer
        S_SETUP: begin
          k_q <= k_q + 3'd1;
          case (k_q)
            3'd0: mop_q <= func_q ? MagW'(keep_rad_q) : MagW'(vs_eff);
            3'd1: mop_q <= MagW'(min_space_q);
            3'd2: begin
              lim_q  <= prod_ext;
              best_q <= (prod_ext << 3) + (prod_ext << 1);
            end
            default: begin
              k_q <= '0;
              if (func_q) begin
                sc_q    <= '0;
                state_q <= S_RMETA;
              end else begin
                lim_q   <= prod_ext;
                ci_q    <= '0;
                bc_q    <= '0;
                rem_q   <= '0;
                dq_q    <= coord_mag(x_q);
                key_q   <= '0;
                state_q <= S_DIV;
              end
            end
          endcase
        end
        // one quotient bit per cycle, three coordinates in turn
        S_DIV: begin
          rem_q <= rem_n;
          dq_q  <= dq_n;
          bc_q  <= bc_q + 5'd1;
          if (bc_q == 5'(CoordW - 1)) begin
            bc_q  <= '0;
            rem_q <= '0;
            key_q <= {kpart, key_q[KeyW-1:16]};
            ci_q  <= ci_q + 2'd1;
            dq_q  <= (ci_q == 2'd0) ? coord_mag(y_q) : coord_mag(z_q);
            if (ci_q == 2'd2) begin
              sc_q    <= '0;
              rd_v_q  <= 1'b0;
              found_q <= 1'b0;
              freef_q <= 1'b0;
              state_q <= S_LOOK;
            end
          end
        end
        // scan all slots for the key and for the first free slot
        S_LOOK: begin
          rd_v_q <= sc_q < SCW'(VOXEL_SLOTS);
          rd_a_q <= sc_q[SW-1:0];
          if (sc_q < SCW'(VOXEL_SLOTS)) begin
            sc_q <= sc_q + 1'b1;
          end
          if (rd_v_q) begin
            if (m_valid && key_rdata == key_q && !found_q) begin
              found_q <= 1'b1;
              hit_q   <= rd_a_q;
              cnt_q   <= m_count;
              cap_q   <= m_cap;
            end
            if (!m_valid && !freef_q) begin
              freef_q <= 1'b1;
              fr_q    <= rd_a_q;
            end
          end else if (sc_q == SCW'(VOXEL_SLOTS)) begin
            if (found_q) begin
              if (cnt_q >= cap_q) begin
                status_q <= ST_FULL;
                vpts_q   <= 6'(cnt_q);
                done_q   <= 1'b1;
                state_q  <= S_IDLE;
              end else begin
                idx_q   <= '0;
                state_q <= S_PNEXT;
              end
            end else if (min_grow_q != 6'd0) begin
              status_q <= ST_SPARSE;
              vpts_q   <= '0;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end else if (!freef_q) begin
              status_q <= ST_TFULL;
              vpts_q   <= '0;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end else begin
              meta_we_q <= 1'b1;
              key_we_q  <= 1'b1;
              meta_wa_q <= fr_q;
              meta_wd_q <= {1'b1, CW'(1), cap_new};
              pt_we_q   <= 1'b1;
              pt_wa_q   <= PAW'(fr_q) * PAW'(POINTS_PER_VOXEL);
              status_q  <= ST_NEW;
              vpts_q    <= 6'd1;
              done_q    <= 1'b1;
              state_q   <= S_IDLE;
            end
          end
        end
        // next stored point of the hit voxel
        S_PNEXT: begin
          if (idx_q < cnt_q) begin
            pa_q    <= PAW'(hit_q) * PAW'(POINTS_PER_VOXEL) + PAW'(idx_q);
            state_q <= S_PRD;
          end else begin
            state_q <= S_DEC;
          end
        end
        // point read in flight
        S_PRD: state_q <= S_PCAP;
        S_PCAP: begin
          px_q    <= pt_rdata[PW-1:2*CoordW];
          py_q    <= pt_rdata[2*CoordW-1:CoordW];
          pz_q    <= pt_rdata[CoordW-1:0];
          k_q     <= '0;
          state_q <= S_DIST;
        end
        // squared distance, one axis per cycle through the squarer
        S_DIST: begin
          k_q <= k_q + 3'd1;
          case (k_q)
            3'd0: mop_q <= abs_diff(px_q, x_q);
            3'd1: mop_q <= abs_diff(py_q, y_q);
            3'd2: begin
              mop_q <= abs_diff(pz_q, z_q);
              acc_q <= prod_ext;
            end
            3'd3: acc_q <= acc_q + prod_ext;
            default: begin
              acc_q   <= acc_q + prod_ext;
              state_q <= func_q ? S_RCMP : S_ICMP;
            end
          endcase
        end
        // keep the nearest distance
        S_ICMP: begin
          if (acc_q < best_q) begin
            best_q <= acc_q;
          end
          idx_q   <= idx_q + 1'b1;
          state_q <= S_PNEXT;
        end
        // spacing and growth decision for an existing voxel
        S_DEC: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
          if (best_q <= lim_q) begin
            status_q <= ST_CLOSE;
            vpts_q   <= 6'(cnt_q);
          end else if (min_grow_q != 6'd0 && NW'(cnt_q) < NW'(min_grow_q)) begin
            status_q <= ST_SPARSE;
            vpts_q   <= 6'(cnt_q);
          end else begin
            pt_we_q   <= 1'b1;
            pt_wa_q   <= PAW'(hit_q) * PAW'(POINTS_PER_VOXEL) + PAW'(cnt_q);
            meta_we_q <= 1'b1;
            meta_wa_q <= hit_q;
            meta_wd_q <= {1'b1, cnt_q + 1'b1, cap_q};
            status_q  <= ST_ADDED;
            vpts_q    <= 6'(cnt_q + 1'b1);
          end
        end
        // removal: slot meta read in flight
        S_RMETA: state_q <= S_RCHK;
        S_RCHK: begin
          if (m_valid) begin
            cap_q   <= m_cap;
            pa_q    <= PAW'(sc_q[SW-1:0]) * PAW'(POINTS_PER_VOXEL);
            state_q <= S_PRD;
          end else if (sc_q == SCW'(VOXEL_SLOTS - 1)) begin
            status_q <= ST_REMOVED;
            vpts_q   <= '0;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            sc_q    <= sc_q + 1'b1;
            state_q <= S_RMETA;
          end
        end
        // free the slot if its first point is beyond the keep radius
        S_RCMP: begin
          if (acc_q > lim_q) begin
            meta_we_q <= 1'b1;
            meta_wa_q <= sc_q[SW-1:0];
            meta_wd_q <= {1'b0, CW'(0), cap_q};
            removed_q <= removed_inc;
          end
          if (sc_q == SCW'(VOXEL_SLOTS - 1)) begin
            status_q <= ST_REMOVED;
            vpts_q   <= '0;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            sc_q    <= sc_q + 1'b1;
            state_q <= S_RMETA;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // outputs
  assign busy             = state_q != S_IDLE;
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign voxel_points_o   = vpts_q;
  assign removed_voxels_o = removed_q;

`ifndef NO_ASSERTIONS
  // an accepted item keeps the unit busy on the next cycle
  ast_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not make the unit busy");

  // one strobe per item: the result strobe drops low right after it is raised
  ast_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  // a removal result carries no point count
  ast_remove_pts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_REMOVED |-> voxel_points_o == 6'd0)
    else $error("removal result with nonzero point count");

  // an insert result carries no removed count
  ast_insert_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_REMOVED |-> removed_voxels_o == 9'd0)
    else $error("insert result with nonzero removed count");
`endif

endmodule
`default_nettype wire
